[rtl/tlyr_pkg.sv]
// Shared constants, codes and types of the tile luma statistics / YUYV to RGB block.
package tlyr_pkg;

   localparam int CFG_W                = 11;
   localparam int CSR_INDEX_W          = 2;
   localparam int PIXEL_W              = 32;
   localparam int CH_W                 = 8;
   localparam int MEAN_W               = 16;
   localparam int VAR_W                = 24;
   localparam int FRAC_W               = 8;
   localparam int MAX_TILE_DIM_DEFAULT = 1024;
   localparam int TILE_DIM_RESET       = 16;

   // Accumulator widths follow from the largest tile the config registers can describe.
   localparam int SUM_W = CH_W + 2 * CFG_W;
   localparam int SQ_W  = 2 * CH_W + 2 * CFG_W;
   localparam int N_W   = 2 * CFG_W;
   localparam int DIV_W = SQ_W + FRAC_W;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_TILE_COLS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_TILE_ROWS = CSR_INDEX_W'(1);

   localparam logic RESULT_PIXEL = 1'b0;
   localparam logic RESULT_STATS = 1'b1;

   typedef enum logic {
      JOB_PIXEL,
      JOB_STATS
   } job_kind_type;

   typedef struct packed {
      job_kind_type     kind;
      logic [CH_W-1:0]  y;
      logic [CH_W-1:0]  u;
      logic [CH_W-1:0]  v;
      logic             tile_end;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  sumsq;
      logic [N_W-1:0]   n;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV_MEAN,
      BK_DIV_VAR,
      BK_SQUARE,
      BK_FINISH
   } back_state_type;

endpackage

[rtl/tlyr_ifs.sv]
// Handshake channel interfaces: pixel words in, results out, register writes.
interface tlyr_req_if import tlyr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

interface tlyr_rsp_if import tlyr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              result_kind;
   logic [CH_W-1:0]   red;
   logic [CH_W-1:0]   green;
   logic [CH_W-1:0]   blue;
   logic [MEAN_W-1:0] luma_mean;
   logic [VAR_W-1:0]  luma_variance;
   logic              tile_end;

   modport source (output valid, output result_kind, output red, output green, output blue,
                   output luma_mean, output luma_variance, output tile_end, input ready);
   modport sink   (input valid, input result_kind, input red, input green, input blue,
                   input luma_mean, input luma_variance, input tile_end, output ready);
endinterface

interface tlyr_csr_if import tlyr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/tlyr_front.sv]
// Front end: config registers, tile position tracking, luma accumulation, job issue.
module tlyr_front import tlyr_pkg::*; #(
   parameter int MAX_TILE_DIM = MAX_TILE_DIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   tlyr_req_if.sink         req,
   tlyr_csr_if.sink         csr,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          job
);

   localparam int DIM_W = (MAX_TILE_DIM > 1) ? $clog2(MAX_TILE_DIM) : 1;

   logic [CFG_W-1:0] cols_ff, cols_in;
   logic [CFG_W-1:0] rows_ff, rows_in;
   logic             convert_ff, convert_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]  sumsq_ff, sumsq_in;

   logic             accept;
   logic [CFG_W-1:0] eff_cols, eff_rows;
   logic [N_W-1:0]   n;
   logic [CH_W-1:0]  y;
   logic [2*CH_W-1:0] ysq;
   logic [SUM_W-1:0] sum_next;
   logic [SQ_W-1:0]  sumsq_next;
   logic             col_last, row_last, tile_last;

   // Zero means one; anything above the supported size is pinned to it.
   function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
      if (raw == '0) begin
         return CFG_W'(1);
      end else if (32'(raw) > MAX_TILE_DIM) begin
         return CFG_W'(MAX_TILE_DIM);
      end else begin
         return raw;
      end
   endfunction

   assign req.ready = !q_status.full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   always_comb begin
      eff_cols   = eff_dim(cols_ff);
      eff_rows   = eff_dim(rows_ff);
      n          = N_W'(eff_cols) * N_W'(eff_rows);
      y          = col_ff[0] ? req.pixel_word[23:16] : req.pixel_word[7:0];
      ysq        = {{CH_W{1'b0}}, y} * {{CH_W{1'b0}}, y};
      sum_next   = sum_ff + SUM_W'(y);
      sumsq_next = sumsq_ff + SQ_W'(ysq);
      col_last   = (32'(col_ff) + 32'd1) >= 32'(eff_cols);
      row_last   = (32'(row_ff) + 32'd1) >= 32'(eff_rows);
      tile_last  = col_last && row_last;

      cols_in    = cols_ff;
      rows_in    = rows_ff;
      convert_in = convert_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      sum_in     = sum_ff;
      sumsq_in   = sumsq_ff;

      if (csr.valid) begin
         case (csr.index)
            REG_TILE_COLS: cols_in = csr.data;
            REG_TILE_ROWS: rows_in = csr.data;
            default: ;
         endcase
      end

      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + DIM_W'(1);
         end else begin
            col_in = col_ff + DIM_W'(1);
         end
         if (!convert_ff) begin
            sum_in   = tile_last ? '0 : sum_next;
            sumsq_in = tile_last ? '0 : sumsq_next;
         end
         if (tile_last) begin
            convert_in = !convert_ff;
         end
      end

      push         = accept && (convert_ff || tile_last);
      job.kind     = convert_ff ? JOB_PIXEL : JOB_STATS;
      job.y        = y;
      job.u        = req.pixel_word[15:8];
      job.v        = req.pixel_word[31:24];
      job.tile_end = tile_last;
      job.sum      = sum_next;
      job.sumsq    = sumsq_next;
      job.n        = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff    <= CFG_W'(TILE_DIM_RESET);
         rows_ff    <= CFG_W'(TILE_DIM_RESET);
         convert_ff <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         sum_ff     <= '0;
         sumsq_ff   <= '0;
      end else begin
         cols_ff    <= cols_in;
         rows_ff    <= rows_in;
         convert_ff <= convert_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         sum_ff     <= sum_in;
         sumsq_ff   <= sumsq_in;
      end
   end

endmodule

[rtl/tlyr_queue.sv]
// Short job queue between the front end and the back end.
module tlyr_queue import tlyr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          wr_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          slots [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
      status.full  = count_ff == CNT_W'(QUEUE_DEPTH);
      status.empty = count_ff == '0;
      head         = slots[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/tlyr_back.sv]
// Back end: two-stage RGB conversion and a shared serial divider for tile statistics.
module tlyr_back import tlyr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type q_status,
   output logic             pop,
   tlyr_rsp_if.source       rsp
);

   localparam int PROD_W = 24;
   localparam int PIX_W  = 26;
   localparam int CNT_W  = $clog2(DIV_W);

   // BT.601 full range, Q14
   localparam logic signed [15:0] C_RV = 16'sd22970;
   localparam logic signed [15:0] C_GU = 16'sd5638;
   localparam logic signed [15:0] C_GV = 16'sd11700;
   localparam logic signed [15:0] C_BU = 16'sd29032;
   localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;

   typedef struct packed {
      logic [CH_W-1:0]           y;
      logic signed [PROD_W-1:0]  rv;
      logic signed [PROD_W-1:0]  gu;
      logic signed [PROD_W-1:0]  gv;
      logic signed [PROD_W-1:0]  bu;
      logic                      tile_end;
   } pix_stage_type;

   typedef struct packed {
      logic              kind;
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic [MEAN_W-1:0] mean;
      logic [VAR_W-1:0]  variance;
      logic              tile_end;
   } result_type;

   back_state_type    state_ff, state_in;
   logic              s1_valid_ff, s1_valid_in;
   pix_stage_type     s1_ff, s1_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        out_ff, out_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [N_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [SQ_W-1:0]   sumsq_ff, sumsq_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic [2*MEAN_W-1:0] msq_ff, msq_in;

   logic                    advance;
   logic signed [8:0]       u_c, v_c;
   logic signed [PIX_W-1:0] base, r_q, g_q, b_q;
   result_type              pix_result;
   logic [N_W:0]            rem_shift;
   logic                    q_bit;
   logic [N_W-1:0]          rem_step;
   logic [DIV_W-1:0]        dvd_step;
   logic                    div_last;
   logic [DIV_W-1:0]        var_diff;
   logic [VAR_W-1:0]        var_sat;

   function automatic logic [CH_W-1:0] clamp_ch(input logic signed [PIX_W-1:0] q);
      if (q[PIX_W-1]) begin
         return '0;
      end else if (|q[PIX_W-2:22]) begin
         return '1;
      end else begin
         return q[21:14];
      end
   endfunction

   always_comb begin
      advance = !rsp_valid_ff || rsp.ready;

      // stage 2 of the pixel path: sum the registered products and clamp
      base = $signed({4'b0000, s1_ff.y, 14'h0000});
      r_q  = base + PIX_W'(s1_ff.rv);
      g_q  = base - PIX_W'(s1_ff.gu) - PIX_W'(s1_ff.gv);
      b_q  = base + PIX_W'(s1_ff.bu);
      pix_result.kind     = RESULT_PIXEL;
      pix_result.red      = clamp_ch(r_q);
      pix_result.green    = clamp_ch(g_q);
      pix_result.blue     = clamp_ch(b_q);
      pix_result.mean     = '0;
      pix_result.variance = '0;
      pix_result.tile_end = s1_ff.tile_end;

      // stage 1 operands
      u_c = $signed({1'b0, head.u}) - CHROMA_BIAS;
      v_c = $signed({1'b0, head.v}) - CHROMA_BIAS;

      // one restoring-division step per cycle
      rem_shift = {rem_ff, dvd_ff[DIV_W-1]};
      q_bit     = rem_shift >= {1'b0, n_ff};
      rem_step  = q_bit ? N_W'(rem_shift - {1'b0, n_ff}) : rem_shift[N_W-1:0];
      dvd_step  = {dvd_ff[DIV_W-2:0], q_bit};
      div_last  = cnt_ff == CNT_W'(DIV_W - 1);

      // variance = a - floor(mean^2 / 256), floored at zero and saturated
      var_diff = dvd_ff - DIV_W'(msq_ff[2*MEAN_W-1:FRAC_W]);
      if (dvd_ff > DIV_W'(msq_ff[2*MEAN_W-1:FRAC_W])) begin
         var_sat = (|var_diff[DIV_W-1:VAR_W]) ? '1 : var_diff[VAR_W-1:0];
      end else begin
         var_sat = '0;
      end

      state_in     = state_ff;
      pop          = 1'b0;
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      sumsq_in     = sumsq_ff;
      mean_in      = mean_ff;
      msq_in       = msq_ff;

      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         out_in       = pix_result;
         s1_valid_in  = 1'b0;
      end

      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               if (head.kind == JOB_STATS) begin
                  pop      = 1'b1;
                  n_in     = head.n;
                  sumsq_in = head.sumsq;
                  dvd_in   = DIV_W'({head.sum, {FRAC_W{1'b0}}});
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = BK_DIV_MEAN;
               end else if (advance) begin
                  pop            = 1'b1;
                  s1_valid_in    = 1'b1;
                  s1_in.y        = head.y;
                  s1_in.rv       = PROD_W'(C_RV) * PROD_W'(v_c);
                  s1_in.gu       = PROD_W'(C_GU) * PROD_W'(u_c);
                  s1_in.gv       = PROD_W'(C_GV) * PROD_W'(v_c);
                  s1_in.bu       = PROD_W'(C_BU) * PROD_W'(u_c);
                  s1_in.tile_end = head.tile_end;
               end
            end
         end
         BK_DIV_MEAN: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               mean_in  = (|dvd_step[DIV_W-1:MEAN_W]) ? '1 : dvd_step[MEAN_W-1:0];
               dvd_in   = {sumsq_ff, {FRAC_W{1'b0}}};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = BK_DIV_VAR;
            end
         end
         BK_DIV_VAR: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               state_in = BK_SQUARE;
            end
         end
         BK_SQUARE: begin
            msq_in   = {{MEAN_W{1'b0}}, mean_ff} * {{MEAN_W{1'b0}}, mean_ff};
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            // earlier pixels still in stage 1 leave first
            if (advance && !s1_valid_ff) begin
               rsp_valid_in    = 1'b1;
               out_in.kind     = RESULT_STATS;
               out_in.red      = '0;
               out_in.green    = '0;
               out_in.blue     = '0;
               out_in.mean     = mean_ff;
               out_in.variance = var_sat;
               out_in.tile_end = 1'b0;
               state_in        = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff    <= s1_in;
      out_ff   <= out_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      n_ff     <= n_in;
      sumsq_ff <= sumsq_in;
      mean_ff  <= mean_in;
      msq_ff   <= msq_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.result_kind   = out_ff.kind;
   assign rsp.red           = out_ff.red;
   assign rsp.green         = out_ff.green;
   assign rsp.blue          = out_ff.blue;
   assign rsp.luma_mean     = out_ff.mean;
   assign rsp.luma_variance = out_ff.variance;
   assign rsp.tile_end      = out_ff.tile_end;

endmodule

[rtl/tile_luma_stats_and_yuyv_to_rgb_unit.sv]
// Top level of the tile luma statistics and YUYV to RGB888 converter.
//
// req_chan takes one 32-bit YUYV word per transaction; every tile arrives twice.
// The first pass accumulates luma and yields a single statistics result (mean Q8.8,
// variance Q16.8) on the tile's last word; the second pass yields one RGB888 pixel
// per word, tile_end marking the tile's last pixel. Results leave on rsp_chan in
// input order. csr_chan writes tile_cols (index 0) and tile_rows (index 1).
//
// Pixel words are taken one per cycle while the job queue has room, and pass through
// the queue, stage 1 and the output register to rsp_chan. For a statistics result
// one restoring divider runs twice, one quotient bit per cycle over a 46-bit
// dividend, then the mean is squared. The 4-entry job queue keeps accepting while
// the divider works and req_chan.ready drops once it fills.
//
// Reset restores 16x16 tiles, returns to the statistics pass and empties the
// queue and the output register. When rsp_chan stalls the result holds in the
// output register, the pixel stage behind it holds, and the queue backs up.
module tile_luma_stats_and_yuyv_to_rgb_unit import tlyr_pkg::*; #(
   parameter int MAX_TILE_DIM = MAX_TILE_DIM_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tlyr_req_if.sink   req_chan,
   tlyr_rsp_if.source rsp_chan,
   tlyr_csr_if.sink   csr_chan
);

   logic             push;
   logic             pop;
   job_type          job;
   job_type          head;
   queue_status_type q_status;

   tlyr_front #(
      .MAX_TILE_DIM(MAX_TILE_DIM)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .csr      (csr_chan),
      .q_status (q_status),
      .push     (push),
      .job      (job)
   );

   tlyr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_job (job),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   tlyr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job popped from an empty queue");

   a_stats_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.result_kind == RESULT_STATS) |->
         (rsp_chan.red == '0 && rsp_chan.green == '0 && rsp_chan.blue == '0 &&
          !rsp_chan.tile_end))
      else $error("statistics result carries pixel fields");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule

[bench/tlyr_result_checker.sv]
// Result checker: predicts every statistics and colour result and compares it on rsp_chan.
module tlyr_result_checker import tlyr_pkg::*; (
   input  logic clock,
   input  logic reset,
   tlyr_req_if  req_mon,
   tlyr_rsp_if  rsp_mon,
   tlyr_csr_if  csr_mon,
   output int   fail_count,
   output int   results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // BT.601 full-range coefficients in Q14
   localparam longint RV_Q14        = 22970;
   localparam longint GU_Q14        = 5638;
   localparam longint GV_Q14        = 11700;
   localparam longint BU_Q14        = 29032;
   localparam int     Q_SHIFT       = 14;
   localparam longint CHROMA_OFFSET = 128;
   localparam longint CH_MAX        = 255;
   localparam longint MEAN_MAX      = 64'hFFFF;
   localparam longint VAR_MAX       = 64'hFF_FFFF;

   typedef struct packed {
      logic              kind;
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic [MEAN_W-1:0] mean;
      logic [VAR_W-1:0]  variance;
      logic              tile_end;
   } tile_result_t;

   logic [CFG_W-1:0] cols_cfg;
   logic [CFG_W-1:0] rows_cfg;
   bit               convert_pass;
   int unsigned      col_pos;
   int unsigned      row_pos;
   longint unsigned  luma_acc;
   longint unsigned  luma_sq_acc;
   tile_result_t     pending_results[$];
   int               mismatches;

   function automatic int unsigned eff_dim(logic [CFG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_TILE_DIM_DEFAULT) return MAX_TILE_DIM_DEFAULT;
      return raw;
   endfunction

   function automatic logic [CH_W-1:0] to_channel(longint q);
      longint whole;
      if (q < 0) return '0;
      whole = q >>> Q_SHIFT;
      if (whole > CH_MAX) return '1;
      return whole[CH_W-1:0];
   endfunction

   // Moves to the next word position; true when the word closed the tile.
   // A counter already at or past a shrunk limit closes its row or tile.
   function automatic bit step_position();
      int unsigned cols;
      int unsigned rows;
      cols = eff_dim(cols_cfg);
      rows = eff_dim(rows_cfg);
      if (col_pos + 1 >= cols) begin
         col_pos = 0;
         if (row_pos + 1 >= rows) begin
            row_pos = 0;
            return 1'b1;
         end
         row_pos++;
         return 1'b0;
      end
      col_pos++;
      return 1'b0;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic predict_word(input logic [PIXEL_W-1:0] w);
      tile_result_t    r;
      longint unsigned luma;
      longint unsigned n;
      longint unsigned mean;
      longint unsigned sq_term;
      longint unsigned mean_term;
      longint unsigned spread;
      longint          base;
      longint          u;
      longint          v;
      luma = col_pos[0] ? w[23:16] : w[7:0];
      r = '0;
      if (!convert_pass) begin
         n = longint'(eff_dim(cols_cfg)) * longint'(eff_dim(rows_cfg));
         luma_acc += luma;
         luma_sq_acc += luma * luma;
         if (step_position()) begin
            mean = (luma_acc << FRAC_W) / n;
            if (mean > MEAN_MAX) mean = MEAN_MAX;
            sq_term = (luma_sq_acc << FRAC_W) / n;
            mean_term = (mean * mean) >> FRAC_W;
            spread = (sq_term > mean_term) ? sq_term - mean_term : 0;
            if (spread > VAR_MAX) spread = VAR_MAX;
            r.kind = RESULT_STATS;
            r.mean = mean[MEAN_W-1:0];
            r.variance = spread[VAR_W-1:0];
            pending_results.push_back(r);
            luma_acc = 0;
            luma_sq_acc = 0;
            convert_pass = 1'b1;
         end
      end else begin
         base = longint'(luma) <<< Q_SHIFT;
         u = longint'(w[15:8]) - CHROMA_OFFSET;
         v = longint'(w[31:24]) - CHROMA_OFFSET;
         r.kind = RESULT_PIXEL;
         r.red = to_channel(base + RV_Q14 * v);
         r.green = to_channel(base - GU_Q14 * u - GV_Q14 * v);
         r.blue = to_channel(base + BU_Q14 * u);
         r.tile_end = step_position();
         if (r.tile_end) convert_pass = 1'b0;
         pending_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin : watch
      tile_result_t got;
      tile_result_t want;
      if (reset) begin
         cols_cfg = TILE_DIM_RESET;
         rows_cfg = TILE_DIM_RESET;
         convert_pass = 1'b0;
         col_pos = 0;
         row_pos = 0;
         luma_acc = 0;
         luma_sq_acc = 0;
         pending_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind = rsp_mon.result_kind;
            got.red = rsp_mon.red;
            got.green = rsp_mon.green;
            got.blue = rsp_mon.blue;
            got.mean = rsp_mon.luma_mean;
            got.variance = rsp_mon.luma_variance;
            got.tile_end = rsp_mon.tile_end;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result transaction: expected none, actual %h",
                        $time, got);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("result_kind", want.kind, got.kind);
               check_field("red", want.red, got.red);
               check_field("green", want.green, got.green);
               check_field("blue", want.blue, got.blue);
               check_field("luma_mean", want.mean, got.mean);
               check_field("luma_variance", want.variance, got.variance);
               check_field("tile_end", want.tile_end, got.tile_end);
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == REG_TILE_COLS) begin
               cols_cfg = csr_mon.data;
            end else if (csr_mon.index == REG_TILE_ROWS) begin
               rows_cfg = csr_mon.data;
            end
         end
         if (req_mon.valid && req_mon.ready) predict_word(req_mon.pixel_word);
      end
      fail_count <= mismatches;
      results_due <= pending_results.size();
   end

endmodule

[bench/tb.sv]
// Testbench top: clock, reset, stimulus on all channels and the final verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tlyr_pkg::*;

   localparam int RANDOM_WORDS = 560;
   localparam int QUIET_WORDS  = 150;
   localparam int DRAIN_CYCLES = 128;
   localparam int RESET_CYCLES = 5;
   localparam int MAX_TILE_WORDS = 64;

   // indexes past the last register; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = CSR_INDEX_W'(3);

   logic clock = 1'b0;
   logic reset;
   bit   quiet;
   int   gap_pct;
   int   words_sent;
   int   fail_count;
   int   results_due;

   tlyr_req_if req_chan ();
   tlyr_rsp_if rsp_chan ();
   tlyr_csr_if csr_chan ();

   tile_luma_stats_and_yuyv_to_rgb_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   tlyr_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_mon     (csr_chan),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #5 clock = ~clock;

   initial begin : time_limit
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver: ready runs with random stall bursts, none once quiet
   initial begin : result_sink
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [PIXEL_W-1:0] w);
      req_chan.valid <= 1'b1;
      req_chan.pixel_word <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // hold the sender until every result is out and the back end has settled
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   task automatic configure(input int cols, input int rows, input bit spare);
      wait_drained();
      write_reg(REG_TILE_COLS, CFG_W'(cols));
      write_reg(REG_TILE_ROWS, CFG_W'(rows));
      if (spare) begin
         write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
      end
      csr_chan.valid <= 1'b0;
   endtask

   // extreme words favor 00/80/FF bytes to reach the clamps and saturation
   function automatic logic [PIXEL_W-1:0] random_word(input bit extreme);
      logic [PIXEL_W-1:0] w;
      w = $urandom;
      if (extreme) begin
         for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 3))
               0: w[8*i +: 8] = 8'h00;
               1: w[8*i +: 8] = 8'hFF;
               2: w[8*i +: 8] = 8'h80;
               default: ;
            endcase
         end
      end
      return w;
   endfunction

   // one tile: statistics pass, then the same words again for the colour pass
   task automatic send_tile(input int n, input bit extreme);
      logic [PIXEL_W-1:0] words[$];
      repeat (n) words.push_back(random_word(extreme));
      foreach (words[i]) send_word(words[i]);
      foreach (words[i]) send_word(words[i]);
   endtask

   initial begin : stimulus
      int cols;
      int rows;
      int cw;
      int rh;
      int n;
      int start;
      req_chan.valid <= 1'b0;
      req_chan.pixel_word <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= REG_TILE_COLS;
      csr_chan.data <= '0;
      reset <= 1'b1;
      quiet = 1'b0;
      gap_pct = 10;
      words_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset 16x16 tile, shrunk mid-tile so the sums overflow the new size
      repeat (4) send_word('1);
      configure(1, 1, 1'b0);
      send_word('1);
      send_word(32'h80FF_8000);

      // luma lane selection and chroma extremes
      configure(1, 2, 1'b0);
      send_word(32'h0000_0000);
      send_word('1);
      send_word(32'h0000_0000);
      send_word('1);
      configure(2, 1, 1'b0);
      send_word(32'h80FF_8000);
      send_word(32'h0000_00FF);
      send_word(32'hFF00_FF00);
      send_word(32'h00FF_00FF);

      // zero dimensions act as one; a spare index write changes nothing
      configure(0, 0, 1'b1);
      send_word($urandom);
      send_word($urandom);

      // shrink during the colour pass: the next pixel closes the tile
      configure(3, 1, 1'b0);
      repeat (4) send_word($urandom);
      configure(1, 1, 1'b0);
      send_word($urandom);

      // widest tile, width above the maximum: full statistics pass, then a
      // 1x1 shrink so the first colour pixel closes it
      configure(2047, 1, 1'b0);
      repeat (MAX_TILE_DIM_DEFAULT) send_word(random_word(1'b0));
      configure(1, 1, 1'b0);
      send_word(random_word(1'b0));

      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         quiet = (words_sent - start >= RANDOM_WORDS - QUIET_WORDS);
         case ($urandom_range(0, 3))
            0: gap_pct = 0;
            1: gap_pct = 3;
            2: gap_pct = 10;
            default: gap_pct = 30;
         endcase
         if (quiet) gap_pct = 0;
         if ($urandom_range(0, 9) == 0) begin
            cols = $urandom_range(MAX_TILE_DIM_DEFAULT, 2047);
            rows = $urandom_range(0, 1) ? 2047 : $urandom_range(0, 4);
         end else begin
            cols = $urandom_range(0, 8);
            rows = $urandom_range(0, 6);
         end
         configure(cols, rows, $urandom_range(0, 3) == 0);
         cw = (cols == 0) ? 1 : (cols > MAX_TILE_DIM_DEFAULT) ? MAX_TILE_DIM_DEFAULT : cols;
         rh = (rows == 0) ? 1 : (rows > MAX_TILE_DIM_DEFAULT) ? MAX_TILE_DIM_DEFAULT : rows;
         n = cw * rh;
         if (n <= MAX_TILE_WORDS) begin
            repeat ($urandom_range(1, 4)) send_tile(n, $urandom_range(0, 3) == 0);
         end
         if (n > MAX_TILE_WORDS || (n > 1 && $urandom_range(0, 7) == 0)) begin
            // partial statistics pass, then 1x1 so the next word closes it
            repeat ($urandom_range(1, (n > 8) ? 8 : n - 1)) send_word(random_word(1'b1));
            configure(1, 1, 1'b0);
            send_word(random_word(1'b1));
            send_word(random_word(1'b1));
         end
      end

      quiet = 1'b1;
      wait_drained();
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
